>>> src/rtcdt_pkg.sv
// Package: shared types, codes and conversion helpers for the RTC date-time packer.
`default_nettype none

package rtcdt_pkg;

  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned StatusW   = 2;

  localparam logic [7:0] YearOffMin = 8'd70;
  localparam logic [7:0] YearOffMax = 8'd169;
  localparam logic [7:0] CenturyOff = 8'd100;
  localparam logic [3:0] MonthMax   = 4'd11;
  localparam logic [3:0] MonthFeb   = 4'd1;
  localparam logic [4:0] HourLimit  = 5'd24;
  localparam logic [5:0] MinLimit   = 6'd60;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_YEAR = 2'd1,
    ST_BAD_DATE = 2'd2,
    ST_BAD_TIME = 2'd3
  } status_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
    logic [5:0] day_of_month;
    logic [3:0] month_zero_based;
    logic [7:0] years_since_1900;
  } dt_in_t;

  typedef struct packed {
    logic [7:0] year_bcd;
    logic [4:0] month_bcd;
    logic [5:0] day_bcd;
    logic [3:0] weekday_bcd;
    logic [5:0] hours_bcd;
    logic [6:0] minutes_bcd;
    logic [6:0] seconds_bcd;
  } dt_bcd_t;

  // Days per month, zero-based month; unused codes give zero.
  function automatic logic [4:0] month_days(input logic [3:0] month);
    logic [4:0] days;
    unique case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   days = 5'd30;
      4'd1:                                      days = 5'd28;
      default:                                   days = 5'd0;
    endcase
    return days;
  endfunction

  // Two-digit binary to BCD by reciprocal multiply (exact below 100).
  function automatic logic [7:0] digits_bcd(input logic [6:0] value);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(value) * 15'd205;
    tens  = prod[14:11];
    units = value - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

endpackage

`default_nettype wire

>>> src/rtc_datetime_validate_bcd_pack.sv
// Top level: validates a binary calendar time and packs it into RTC BCD register bytes.
// One beat is taken every cycle unless a stalled result holds in_tready low. The input
// register takes the beat at the accepting edge, and the checks and BCD conversion between
// it and the result register fill the result register as soon as that register is free, so
// each result passes the input and result registers. While a result waits, the input register
// can still take one beat; in_tready then falls until the waiting result is taken.
`default_nettype none

module rtc_datetime_validate_bcd_pack (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // years_since_1900[7:0], month_zero_based[11:8], day_of_month[17:12],
  // weekday[20:18], hour[25:21], minute[31:26], second[37:32], zero[39:38]
  input  wire logic [rtcdt_pkg::InTdataW-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // seconds_bcd[6:0], minutes_bcd[13:7], hours_bcd[19:14], weekday_bcd[23:20],
  // day_bcd[29:24], month_bcd[34:30], year_bcd[42:35], zero[47:43]
  output logic [rtcdt_pkg::OutTdataW-1:0]         out_tdata,
  // status[1:0]
  output logic [rtcdt_pkg::StatusW-1:0]           out_tuser
);

  logic                 in_valid_r;
  logic                 in_valid_nxt;
  rtcdt_pkg::dt_in_t    dt_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  rtcdt_pkg::dt_bcd_t   bcd_r;
  rtcdt_pkg::status_t   status_r;
  rtcdt_pkg::status_t   status_c;
  rtcdt_pkg::dt_bcd_t   bcd_c;
  logic                 out_free;
  logic                 in_take;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_take ? 1'b1 : (out_free ? 1'b0 : in_valid_r);
  assign out_valid_nxt = out_free ? in_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      dt_r <= rtcdt_pkg::dt_in_t'(in_tdata[$bits(rtcdt_pkg::dt_in_t)-1:0]);
    end
    if (out_free && in_valid_r) begin
      bcd_r    <= bcd_c;
      status_r <= status_c;
    end
  end

  rtcdt_check u_check (
    .dt_i     (dt_r),
    .status_o (status_c)
  );

  rtcdt_bcd u_bcd (
    .dt_i     (dt_r),
    .status_i (status_c),
    .bcd_o    (bcd_c)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(rtcdt_pkg::OutTdataW - $bits(rtcdt_pkg::dt_bcd_t))'(0), bcd_r};
  assign out_tuser  = status_r;

endmodule

`default_nettype wire

>>> src/rtcdt_check.sv
// Range and calendar checks giving the status of one date-time beat.
`default_nettype none

module rtcdt_check (
  input  var rtcdt_pkg::dt_in_t  dt_i,
  output rtcdt_pkg::status_t     status_o
);

  logic       year_ok;
  logic       leap;
  logic [5:0] day_limit;
  logic       date_bad;
  logic       time_bad;

  assign year_ok   = (dt_i.years_since_1900 >= rtcdt_pkg::YearOffMin) &&
                     (dt_i.years_since_1900 <= rtcdt_pkg::YearOffMax);
  // Within 1970..2069 only 2000 is a century year, and it is divisible by 400.
  assign leap      = (dt_i.years_since_1900[1:0] == 2'b00);
  assign day_limit = {1'b0, rtcdt_pkg::month_days(dt_i.month_zero_based)} +
                     6'((dt_i.month_zero_based == rtcdt_pkg::MonthFeb) && leap);
  assign date_bad  = (dt_i.month_zero_based > rtcdt_pkg::MonthMax) ||
                     (dt_i.day_of_month == 6'd0) ||
                     (dt_i.day_of_month > day_limit);
  assign time_bad  = (dt_i.hour >= rtcdt_pkg::HourLimit) ||
                     (dt_i.minute >= rtcdt_pkg::MinLimit) ||
                     (dt_i.second >= rtcdt_pkg::MinLimit);

  always_comb begin
    if (!year_ok) begin
      status_o = rtcdt_pkg::ST_BAD_YEAR;
    end else if (date_bad) begin
      status_o = rtcdt_pkg::ST_BAD_DATE;
    end else if (time_bad) begin
      status_o = rtcdt_pkg::ST_BAD_TIME;
    end else begin
      status_o = rtcdt_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

>>> src/rtcdt_bcd.sv
// BCD packing of the RTC time registers, zeroed on a failed check.
`default_nettype none

module rtcdt_bcd (
  input  var rtcdt_pkg::dt_in_t  dt_i,
  input  var rtcdt_pkg::status_t status_i,
  output rtcdt_pkg::dt_bcd_t     bcd_o
);

  logic [6:0] year_2d;
  logic [7:0] sec_b;
  logic [7:0] min_b;
  logic [7:0] hour_b;
  logic [7:0] day_b;
  logic [7:0] mon_b;
  logic [7:0] year_b;

  assign year_2d = (dt_i.years_since_1900 >= rtcdt_pkg::CenturyOff) ?
                   7'(dt_i.years_since_1900 - rtcdt_pkg::CenturyOff) :
                   dt_i.years_since_1900[6:0];

  assign sec_b  = rtcdt_pkg::digits_bcd({1'b0, dt_i.second});
  assign min_b  = rtcdt_pkg::digits_bcd({1'b0, dt_i.minute});
  assign hour_b = rtcdt_pkg::digits_bcd({2'b00, dt_i.hour});
  assign day_b  = rtcdt_pkg::digits_bcd({1'b0, dt_i.day_of_month});
  assign mon_b  = rtcdt_pkg::digits_bcd({3'b000, dt_i.month_zero_based} + 7'd1);
  assign year_b = rtcdt_pkg::digits_bcd(year_2d);

  always_comb begin
    if (status_i == rtcdt_pkg::ST_OK) begin
      bcd_o.seconds_bcd = sec_b[6:0];
      bcd_o.minutes_bcd = min_b[6:0];
      bcd_o.hours_bcd   = hour_b[5:0];
      // weekday plus one never exceeds 8, so binary equals BCD
      bcd_o.weekday_bcd = {1'b0, dt_i.weekday} + 4'd1;
      bcd_o.day_bcd     = day_b[5:0];
      bcd_o.month_bcd   = mon_b[4:0];
      bcd_o.year_bcd    = year_b;
    end else begin
      bcd_o = '0;
    end
  end

endmodule

`default_nettype wire

>>> src/rtcdt_checker.sv
// Port-level checker for the RTC date-time packer, bound to the top level.
`default_nettype none

module rtcdt_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic [rtcdt_pkg::InTdataW-1:0]     in_tdata,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [rtcdt_pkg::OutTdataW-1:0]    out_tdata,
  input wire logic [rtcdt_pkg::StatusW-1:0]      out_tuser
);

  logic unused_in;
  assign unused_in = ^in_tdata;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != rtcdt_pkg::ST_OK) |-> out_tdata == '0)
    else $error("failed check with non-zero bytes");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 out_tready |=> out_tvalid)
    else $error("accepted beat did not reach the result register");

endmodule

bind rtc_datetime_validate_bcd_pack rtcdt_checker u_rtcdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
